// ----- hw/rtl/assert_macros.svh -----
// Assertion helper macros for the shared free-list stack block.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted (active-low).
`define KSFL_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked check that also holds during reset.
`define KSFL_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/ksfl_pkg.sv -----
// Shared types and codes for the k-stacks shared free-list block.
// No dependencies; used by the channel interfaces and the top level.
package ksfl_pkg;

  typedef logic        [1:0]  func_t;
  typedef logic        [2:0]  sid_t;
  typedef logic signed [31:0] value_t;
  typedef logic        [1:0]  status_t;

  // operation codes
  localparam func_t FUNC_PUSH = 2'd0;
  localparam func_t FUNC_POP  = 2'd1;
  localparam func_t FUNC_PEEK = 2'd2;

  // result status codes
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

endpackage

// ----- hw/rtl/ksfl_if.sv -----
// Valid/ready channel interfaces for the request and result streams.
// Depends on ksfl_pkg for payload types.
interface ksfl_in_if;
  logic              valid;
  logic              ready;
  ksfl_pkg::func_t   func;
  ksfl_pkg::sid_t    stack_id;
  ksfl_pkg::value_t  push_value;

  modport source (output valid, output func, output stack_id, output push_value,
                  input ready);
  modport sink   (input valid, input func, input stack_id, input push_value,
                  output ready);
endinterface

interface ksfl_out_if;
  logic              valid;
  logic              ready;
  ksfl_pkg::value_t  top_value;
  ksfl_pkg::status_t status;
  logic              stack_now_empty;

  modport source (output valid, output top_value, output status, output stack_now_empty,
                  input ready);
  modport sink   (input valid, input top_value, input status, input stack_now_empty,
                  output ready);
endinterface

// ----- hw/rtl/ksfl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; no reset on contents.
module ksfl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];  // old data on same-address write
    end
  end

endmodule

// ----- hw/rtl/k_stacks_shared_free_list_core.sv -----
// Top level of the k-stacks shared free-list block.
// Depends on ksfl_pkg, ksfl_if (channels), ksfl_ram and assert_macros.svh.
//
// Usage:
//  - in_bus carries one request beat: func (push/pop/peek), stack_id, push_value.
//    out_bus returns exactly one result beat per request, in order:
//    top_value, status (ok / full / empty), stack_now_empty.
//  - Path: a request accepted from in_bus is held in the operand stage, then moves
//    into the result register, from which out_bus offers its result beat.
//  - Throughput: one request per cycle, sustained while out_bus.ready is high.
//    The link and data RAM reads for a request are issued at its accept edge,
//    with addresses formed from the state the preceding request leaves, plus a
//    write-to-read bypass; that RAM read port is what sets this rate.
//  - Reset (rst_n low, synchronous): all stacks empty, free list 0,1,2,...
//    No clearing pass: a high-water mark marks link entries never written,
//    which read as their reset value (index + 1). The block takes requests
//    as soon as reset is released.
//  - Stall: if out_bus.ready stays low, the result register holds its beat,
//    the operand stage holds one more request, and in_bus.ready then drops.
//    State changes only when a request moves into the result register.
`include "assert_macros.svh"

module k_stacks_shared_free_list_core #(
  parameter int STORE_DEPTH = 64,
  parameter int NUM_STACKS  = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  ksfl_in_if.sink          in_bus,
  ksfl_out_if.source       out_bus
);

  // Pointer holds a slot index or the null value STORE_DEPTH.
  localparam int PW = $clog2(STORE_DEPTH + 1);
  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam logic [PW-1:0] NullPtr = PW'(STORE_DEPTH);

  // ---------------------------------------------------------------- state
  logic [PW-1:0] tops_r [NUM_STACKS];
  logic [PW-1:0] free_head_r, free_head_nxt;
  logic [PW-1:0] hw_r, hw_nxt;            // link entries >= hw_r never written

  // ---------------------------------------------------------------- operand stage
  logic                 s_valid_r;
  ksfl_pkg::func_t      s_func_r;
  logic                 s_in_range_r;
  logic [SW-1:0]        s_idx_r;
  ksfl_pkg::value_t     s_value_r;
  logic [PW-1:0]        s_top_r;
  logic                 link_byp_r, link_old_r, data_byp_r;
  logic [PW-1:0]        link_bypd_r, link_dflt_r;
  ksfl_pkg::value_t     data_bypd_r;

  // ---------------------------------------------------------------- result register
  logic                 out_valid_r;
  ksfl_pkg::value_t     out_top_value_r;
  ksfl_pkg::status_t    out_status_r;
  logic                 out_empty_r;

  // ---------------------------------------------------------------- handshake
  logic s_fire, in_fire;
  assign s_fire       = s_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = !s_valid_r || s_fire;
  assign in_fire      = in_bus.valid && in_bus.ready;

  // ---------------------------------------------------------------- RAMs
  logic [PW-1:0]    link_q;
  ksfl_pkg::value_t data_q;
  logic             l_we, d_we, t_we;
  logic [PW-1:0]    l_waddr, l_wdata, t_wdata;
  logic [PW-1:0]    link_raddr, data_raddr;

  ksfl_ram #(.WIDTH(PW), .DEPTH(STORE_DEPTH)) u_link_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr[AW-1:0]),
    .wdata (l_wdata),
    .re    (in_fire),
    .raddr (link_raddr[AW-1:0]),
    .rdata (link_q)
  );

  ksfl_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_data_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (free_head_r[AW-1:0]),
    .wdata (s_value_r),
    .re    (in_fire),
    .raddr (data_raddr[AW-1:0]),
    .rdata (data_q)
  );

  // ---------------------------------------------------------------- execute
  logic [PW-1:0]    link_rd;
  ksfl_pkg::value_t data_rd;
  logic             head_ok, top_ok, do_push, do_pop;

  // Read data with forwarding of the write made at the read's own edge.
  assign link_rd = link_byp_r ? link_bypd_r : (link_old_r ? link_q : link_dflt_r);
  assign data_rd = data_byp_r ? data_bypd_r : data_q;

  assign head_ok = free_head_r < NullPtr;
  assign top_ok  = s_top_r < NullPtr;
  assign do_push = s_fire && s_in_range_r && (s_func_r == ksfl_pkg::FUNC_PUSH) && head_ok;
  assign do_pop  = s_fire && s_in_range_r && (s_func_r == ksfl_pkg::FUNC_POP) && top_ok;

  // push: slot = free head, link[slot] = old top, top = slot, head = old link[slot]
  // pop:  top = link[top], link[top] = head, head = old top
  assign d_we    = do_push;
  assign l_we    = do_push || do_pop;
  assign l_waddr = do_push ? free_head_r : s_top_r;
  assign l_wdata = do_push ? s_top_r : free_head_r;
  assign t_we    = l_we;
  assign t_wdata = do_push ? free_head_r : link_rd;

  assign free_head_nxt = do_push ? link_rd : (do_pop ? s_top_r : free_head_r);
  assign hw_nxt = (do_push && (free_head_r == hw_r)) ? hw_r + PW'(1) : hw_r;

  // Result fields
  ksfl_pkg::status_t st_c;
  ksfl_pkg::value_t  tv_c;
  logic [PW-1:0]     new_top_c;
  logic              empty_c;

  always_comb begin
    st_c      = ksfl_pkg::ST_OK;
    tv_c      = '0;
    new_top_c = s_top_r;
    if (!s_in_range_r) begin
      new_top_c = NullPtr;
      case (s_func_r) inside
        ksfl_pkg::FUNC_PUSH:                     st_c = ksfl_pkg::ST_FULL;
        ksfl_pkg::FUNC_POP, ksfl_pkg::FUNC_PEEK: st_c = ksfl_pkg::ST_EMPTY;
        default:                                 st_c = ksfl_pkg::ST_OK;
      endcase
    end else begin
      case (s_func_r)
        ksfl_pkg::FUNC_PUSH: begin
          if (head_ok) new_top_c = free_head_r;
          else         st_c = ksfl_pkg::ST_FULL;
        end
        ksfl_pkg::FUNC_POP: begin
          if (top_ok) new_top_c = link_rd;
          else        st_c = ksfl_pkg::ST_EMPTY;
        end
        ksfl_pkg::FUNC_PEEK: begin
          if (top_ok) tv_c = data_rd;
          else        st_c = ksfl_pkg::ST_EMPTY;
        end
        default: st_c = ksfl_pkg::ST_OK;
      endcase
    end
  end

  assign empty_c = !(new_top_c < NullPtr);

  // ---------------------------------------------------------------- read address
  // Addresses come from the state as it will be after this edge's update.
  logic [SW-1:0] in_idx;
  logic          in_in_range;
  logic [PW-1:0] top_sel;

  assign in_idx      = SW'(in_bus.stack_id);
  assign in_in_range = 32'(in_bus.stack_id) < NUM_STACKS;

  always_comb begin
    top_sel = NullPtr;
    if (in_in_range) begin
      top_sel = (t_we && (s_idx_r == in_idx)) ? t_wdata : tops_r[in_idx];
    end
  end

  assign link_raddr = (in_bus.func == ksfl_pkg::FUNC_PUSH) ? free_head_nxt : top_sel;
  assign data_raddr = top_sel;

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_STACKS; i++) begin
        tops_r[i] <= NullPtr;
      end
      free_head_r <= '0;
      hw_r        <= '0;
      s_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (t_we) tops_r[s_idx_r] <= t_wdata;
      free_head_r <= free_head_nxt;
      hw_r        <= hw_nxt;

      if (in_fire)     s_valid_r <= 1'b1;
      else if (s_fire) s_valid_r <= 1'b0;

      if (s_fire)             out_valid_r <= 1'b1;
      else if (out_bus.ready) out_valid_r <= 1'b0;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s_func_r     <= in_bus.func;
      s_in_range_r <= in_in_range;
      s_idx_r      <= in_idx;
      s_value_r    <= in_bus.push_value;
      s_top_r      <= top_sel;
      link_byp_r   <= l_we && (l_waddr == link_raddr);
      link_bypd_r  <= l_wdata;
      link_old_r   <= link_raddr < hw_r;
      link_dflt_r  <= link_raddr + PW'(1);
      data_byp_r   <= d_we && (free_head_r == data_raddr);
      data_bypd_r  <= s_value_r;
    end
    if (s_fire) begin
      out_top_value_r <= tv_c;
      out_status_r    <= st_c;
      out_empty_r     <= empty_c;
    end
  end

  assign out_bus.valid           = out_valid_r;
  assign out_bus.top_value       = out_top_value_r;
  assign out_bus.status          = out_status_r;
  assign out_bus.stack_now_empty = out_empty_r;

  // ---------------------------------------------------------------- checks
  // free head is unknown until the first reset edge; vacuous while in reset
  `KSFL_ASSERT_ALWAYS(a_head_in_range, clk, !rst_n || (free_head_r <= NullPtr), "free head out of range")

  `KSFL_ASSERT(a_push_moves_head, clk, rst_n,
    do_push |=> free_head_r != $past(free_head_r), "push left free head unchanged")

  `KSFL_ASSERT(a_stall_freezes_state, clk, rst_n,
    (s_valid_r && out_valid_r && !out_bus.ready) |=> $stable(free_head_r) && $stable(hw_r),
    "state changed while result stalled")

  `KSFL_ASSERT(a_watermark_grows, clk, rst_n,
    1'b1 |=> hw_r >= $past(hw_r), "link high-water mark went backward")

endmodule

// ----- tb/ksfl_tb_pkg.sv -----
// Scoreboard for the shared free-list stack block: a cycle-free model of the
// stacks plus an in-order queue of predicted replies. Depends on ksfl_pkg.
`timescale 1ns / 100ps

package ksfl_tb_pkg;
  import ksfl_pkg::*;

  localparam int          SLOTS     = 64;
  localparam int          STACKS    = 8;
  localparam logic [6:0]  NULL_SLOT = 7'd64;
  localparam func_t       FUNC_NOP  = 2'd3;  // unused code, must be a no-op

  typedef struct {
    value_t  top_value;
    status_t status;
    logic    stack_now_empty;
  } stack_reply_t;

  class stack_scoreboard;
    int unsigned  errors;
    int unsigned  beats_seen;
    stack_reply_t replies_due[$];
    value_t       slot_data[SLOTS];
    logic [6:0]   slot_link[SLOTS];
    logic [6:0]   stack_top[STACKS];
    logic [6:0]   free_head;

    function new();
      errors     = 0;
      beats_seen = 0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_data[i] = '0;
        slot_link[i] = 7'(i + 1);
      end
      for (int i = 0; i < STACKS; i++) stack_top[i] = NULL_SLOT;
      free_head = '0;
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    // Applies one request to the shadow stacks and returns its reply.
    function stack_reply_t predict_stack_op(func_t f, sid_t s, value_t v);
      stack_reply_t r;
      logic [6:0]   top;
      logic [6:0]   slot;
      r.top_value = '0;
      r.status    = ST_OK;
      top         = stack_top[s];
      case (f)
        FUNC_PUSH: begin
          if (free_head == NULL_SLOT) begin
            r.status = ST_FULL;
          end else begin
            slot            = free_head;
            slot_data[slot] = v;
            free_head       = slot_link[slot];
            slot_link[slot] = top;
            stack_top[s]    = slot;
          end
        end
        FUNC_POP: begin
          if (top == NULL_SLOT) begin
            r.status = ST_EMPTY;
          end else begin
            stack_top[s]   = slot_link[top];
            slot_link[top] = free_head;
            free_head      = top;
          end
        end
        FUNC_PEEK: begin
          if (top == NULL_SLOT) r.status = ST_EMPTY;
          else                  r.top_value = slot_data[top];
        end
        default: ;
      endcase
      r.stack_now_empty = (stack_top[s] == NULL_SLOT);
      return r;
    endfunction

    function void note_request(func_t f, sid_t s, value_t v);
      replies_due.push_back(predict_stack_op(f, s, v));
    endfunction

    task report(string what);
      $display("MISMATCH @%0t: %s", $time, what);
      errors++;
    endtask

    task check_result(value_t top, status_t st, logic now_empty);
      stack_reply_t exp;
      if (replies_due.size() == 0) begin
        report($sformatf("result beat %0d arrived with no request outstanding", beats_seen));
      end else begin
        exp = replies_due.pop_front();
        if (top !== exp.top_value)
          report($sformatf("beat %0d top_value %h, want %h", beats_seen, top, exp.top_value));
        if (st !== exp.status)
          report($sformatf("beat %0d status %0d, want %0d", beats_seen, st, exp.status));
        if (now_empty !== exp.stack_now_empty)
          report($sformatf("beat %0d stack_now_empty %b, want %b", beats_seen, now_empty,
                           exp.stack_now_empty));
      end
      beats_seen++;
    endtask

    task check_drained();
      if (replies_due.size() != 0)
        report($sformatf("%0d replies never arrived", replies_due.size()));
    endtask
  endclass

endpackage

// ----- tb/testbench.sv -----
// Top-level testbench for k_stacks_shared_free_list_core: directed and random
// push/pop/peek traffic with random idling. Depends on ksfl_pkg, ksfl_if, ksfl_tb_pkg.
`timescale 1ns / 100ps

module testbench;
  import ksfl_pkg::*;
  import ksfl_tb_pkg::*;

  localparam int RANDOM_ITEMS = 1350;
  localparam int PHASE_LEN    = 120;
  localparam int CALM_TAIL    = 200;   // last items run with no idling at all
  localparam int DRAIN_LIMIT  = 2000;  // cycles allowed for replies to come home

  // traffic mixes for the random part
  typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_EVEN} traffic_mix_t;

  logic clk = 1'b0;
  logic rst_n;

  ksfl_in_if  in_bus();
  ksfl_out_if out_bus();

  k_stacks_shared_free_list_core #(
    .STORE_DEPTH(SLOTS),
    .NUM_STACKS (STACKS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  stack_scoreboard sb = new();

  // idling switches, flipped per phase by the stimulus process
  logic src_gaps  = 1'b0;
  logic sink_gaps = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hard stop in case the block hangs on a handshake.
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Result sink: ready drops in random bursts while sink_gaps is set.
  initial begin
    out_bus.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (sink_gaps && $urandom_range(0, 5) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Result monitor. Sampled mid-cycle: nothing moves between the falling edge
  // and the next rising edge, so these are the values that edge will see.
  always @(negedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready)
      sb.check_result(out_bus.top_value, out_bus.status, out_bus.stack_now_empty);
  end

  // Drives one request beat and returns at the edge that accepts it.
  // Entered at a rising edge; valid gets exactly one NBA per edge.
  task automatic send_request(func_t f, sid_t s, value_t v);
    logic taken;
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.func       <= f;
    in_bus.stack_id   <= s;
    in_bus.push_value <= v;
    do begin
      @(negedge clk);
      taken = in_bus.ready;
      @(posedge clk);
    end while (!taken);
    sb.note_request(f, s, v);
  endtask

  // Mostly full-range random, with the corner values now and then.
  function automatic value_t pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return '0;
      3:       return -32'sd1;
      default: return value_t'($urandom);
    endcase
  endfunction

  // Weighted op choice; fill phases run the store out of slots,
  // drain phases empty stacks and pop past the bottom.
  function automatic func_t pick_func(traffic_mix_t mix);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return FUNC_NOP;
    case (mix)
      MIX_FILL:  return (roll < 80) ? FUNC_PUSH : (roll < 90) ? FUNC_POP : FUNC_PEEK;
      MIX_DRAIN: return (roll < 20) ? FUNC_PUSH : (roll < 75) ? FUNC_POP : FUNC_PEEK;
      default:   return (roll < 45) ? FUNC_PUSH : (roll < 78) ? FUNC_POP : FUNC_PEEK;
    endcase
  endfunction

  initial begin
    traffic_mix_t mix;
    sid_t         focus;
    sid_t         sid;
    int           waited;

    rst_n             <= 1'b0;
    in_bus.valid      <= 1'b0;
    in_bus.func       <= FUNC_PUSH;
    in_bus.stack_id   <= '0;
    in_bus.push_value <= '0;
    mix    = MIX_EVEN;
    focus  = '0;
    waited = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: value extremes, the two end stacks, every op, the empty-stack
    // cases on pop and peek, and the unused op code on an empty and a non-empty stack.
    send_request(FUNC_PUSH, 3'd0, 32'sh7FFF_FFFF);
    send_request(FUNC_PUSH, 3'd0, 32'sh8000_0000);
    send_request(FUNC_PEEK, 3'd0, '0);
    send_request(FUNC_PUSH, 3'd7, '0);
    send_request(FUNC_PUSH, 3'd7, -32'sd1);
    send_request(FUNC_PEEK, 3'd7, 32'sh1234_5678);
    send_request(FUNC_POP,  3'd7, '0);
    send_request(FUNC_PEEK, 3'd7, '0);
    send_request(FUNC_POP,  3'd7, '0);
    send_request(FUNC_POP,  3'd7, '0);
    send_request(FUNC_PEEK, 3'd7, '0);
    send_request(FUNC_NOP,  3'd7, -32'sd1);
    send_request(FUNC_NOP,  3'd0, 32'sh5A5A_5A5A);
    send_request(FUNC_POP,  3'd0, '0);
    send_request(FUNC_PEEK, 3'd0, '0);
    send_request(FUNC_POP,  3'd0, '0);
    send_request(FUNC_POP,  3'd0, '0);
    send_request(FUNC_PUSH, 3'd3, 32'sh5555_5555);
    send_request(FUNC_PUSH, 3'd3, 32'shAAAA_AAAA);
    send_request(FUNC_PEEK, 3'd3, '0);
    send_request(FUNC_POP,  3'd3, '0);
    send_request(FUNC_PEEK, 3'd3, '0);
    send_request(FUNC_POP,  3'd3, '0);

    // Random: each phase picks a fill, drain or even mix at random so the free list
    // runs dry (store full) and stacks run empty again and again.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_LEN == 0) begin
        mix       = traffic_mix_t'($urandom_range(0, 2));
        focus     = sid_t'($urandom_range(0, STACKS - 1));
        src_gaps  = $urandom_range(0, 2) != 0;
        sink_gaps = $urandom_range(0, 2) != 0;
      end
      if (n >= RANDOM_ITEMS - CALM_TAIL) begin
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
      end
      // half the traffic on one stack so deep stacks build up
      sid = $urandom_range(0, 1) ? focus : sid_t'($urandom_range(0, STACKS - 1));
      send_request(pick_func(mix), sid, pick_value());
    end
    in_bus.valid <= 1'b0;

    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);   // catch any stray beat after the last reply
    sb.check_drained();

    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
